// File: hdl/sls_pkg.sv
// Shared definitions for the serial link loss supervisor.
// Holds action codes, link state codes, register indexes and reset values.
// No dependencies.
package sls_pkg;

    // Action codes carried by the input request.
    localparam logic [2:0] ACT_TICK         = 3'd0;
    localparam logic [2:0] ACT_FRAME_CHECK  = 3'd1;
    localparam logic [2:0] ACT_SUPERVISE    = 3'd2;
    localparam logic [2:0] ACT_MANUAL_RESET = 3'd3;
    localparam logic [2:0] ACT_NONE         = 3'd4;

    // Link state codes as reported on the result port.
    localparam logic [1:0] LINK_NORMAL       = 2'd0;
    localparam logic [1:0] LINK_SIGNAL_LOST  = 2'd1;
    localparam logic [1:0] LINK_POWER_LOST   = 2'd2;
    localparam logic [1:0] LINK_RECONNECTING = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SIGNAL_LOST_MS        = 2'd0;
    localparam logic [1:0] CFG_POWER_LOST_MS         = 2'd1;
    localparam logic [1:0] CFG_CRC_FAIL_LIMIT        = 2'd2;
    localparam logic [1:0] CFG_RECONNECT_INTERVAL_MS = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] RST_SIGNAL_LOST_MS        = 16'd100;
    localparam logic [15:0] RST_POWER_LOST_MS         = 16'd1000;
    localparam logic [7:0]  RST_CRC_FAIL_LIMIT        = 8'd5;
    localparam logic [15:0] RST_RECONNECT_INTERVAL_MS = 16'd5000;

    // Saturation point of the millisecond counters.
    localparam logic [15:0] TIME_MAX = 16'hFFFF;

    // Internal link mode, one-hot.
    typedef enum logic [3:0] {
        MODE_NORMAL       = 4'b0001,
        MODE_SIGNAL_LOST  = 4'b0010,
        MODE_POWER_LOST   = 4'b0100,
        MODE_RECONNECTING = 4'b1000
    } link_mode_t;

    // Map the one-hot mode to its reported code.
    function automatic logic [1:0] mode_code(input link_mode_t mode);
        logic [1:0] code;
        case (mode)
            MODE_NORMAL:      code = LINK_NORMAL;
            MODE_SIGNAL_LOST: code = LINK_SIGNAL_LOST;
            MODE_POWER_LOST:  code = LINK_POWER_LOST;
            default:          code = LINK_RECONNECTING;
        endcase
        return code;
    endfunction

endpackage

// File: hdl/serial_link_loss_supervisor.sv
// Top level of the serial link loss supervisor.
// Input register, single-pass state update and result register.
// Depends on sls_pkg.

// The block takes requests while in_stall is low and returns one result per
// request, in order. A request is first held in the input register, then its
// result is loaded into the result register, where out_valid rises and the
// result stays until it is taken while out_stall is low.
// While the result register holds an untaken result and out_stall is high,
// in_stall rises as soon as the input register is also full, so throughput
// stays at one request per cycle whenever the downstream side takes results.
// The link state, the two saturating millisecond counters, the CRC failure
// run and the valid flag all update in the cycle a request leaves the input
// register. Configuration writes take effect on the next clock edge.
module serial_link_loss_supervisor
    import sls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic        crc_good,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  link_state,
    output logic        data_valid,
    output logic        power_lost,
    output logic [7:0]  crc_fail_count,
    output logic        restart_request
);

    // Configuration registers.
    logic [15:0] sig_timeout_ms_reg;
    logic [15:0] pwr_timeout_ms_reg;
    logic [7:0]  crc_fail_limit_reg;
    logic [15:0] reconnect_interval_ms_reg;

    // Input stage.
    logic        s1_valid_reg;
    logic [2:0]  s1_action_reg;
    logic        s1_crc_good_reg;

    // Supervisor state.
    link_mode_t  mode_reg, mode_next;
    logic [15:0] ms_good_reg, ms_good_next;
    logic [15:0] ms_restart_reg, ms_restart_next;
    logic [7:0]  fail_run_reg, fail_run_next;
    logic        last_good_reg, last_good_next;
    logic        valid_flag_reg, valid_flag_next;
    logic        restart_next;
    logic        do_update_valid;
    logic        do_restart;

    // Result register.
    logic        out_valid_reg;
    logic [1:0]  link_state_reg;
    logic        data_valid_reg;
    logic        power_lost_reg;
    logic [7:0]  fail_count_reg;
    logic        restart_reg;

    logic        advance;

    // The input stage moves on when the result register is free or being taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;

    // Configuration writes; unknown indexes cannot occur with a two-bit index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_timeout_ms_reg        <= RST_SIGNAL_LOST_MS;
            pwr_timeout_ms_reg        <= RST_POWER_LOST_MS;
            crc_fail_limit_reg        <= RST_CRC_FAIL_LIMIT;
            reconnect_interval_ms_reg <= RST_RECONNECT_INTERVAL_MS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SIGNAL_LOST_MS:        sig_timeout_ms_reg        <= cfg_data;
                CFG_POWER_LOST_MS:         pwr_timeout_ms_reg        <= cfg_data;
                CFG_CRC_FAIL_LIMIT:        crc_fail_limit_reg        <= cfg_data[7:0];
                CFG_RECONNECT_INTERVAL_MS: reconnect_interval_ms_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_action_reg   <= action;
            s1_crc_good_reg <= crc_good;
        end
    end

    // Next state for the request in the input register.
    always_comb
    begin
        mode_next       = mode_reg;
        ms_good_next    = ms_good_reg;
        ms_restart_next = ms_restart_reg;
        fail_run_next   = fail_run_reg;
        last_good_next  = last_good_reg;
        valid_flag_next = valid_flag_reg;
        restart_next    = 1'b0;
        do_update_valid = 1'b0;
        do_restart      = 1'b0;

        case (s1_action_reg)
            ACT_TICK:
            begin
                if (ms_good_reg != TIME_MAX)
                begin
                    ms_good_next = ms_good_reg + 16'd1;
                end
                if (ms_restart_reg != TIME_MAX)
                begin
                    ms_restart_next = ms_restart_reg + 16'd1;
                end
            end
            ACT_FRAME_CHECK:
            begin
                last_good_next  = s1_crc_good_reg;
                do_update_valid = 1'b1;
                if (s1_crc_good_reg)
                begin
                    fail_run_next = 8'd0;
                    ms_good_next  = 16'd0;
                    mode_next     = MODE_NORMAL;
                end
                else if (fail_run_reg < crc_fail_limit_reg)
                begin
                    fail_run_next = fail_run_reg + 8'd1;
                end
            end
            ACT_SUPERVISE:
            begin
                do_update_valid = 1'b1;
                case (mode_reg)
                    MODE_NORMAL:
                    begin
                        if (ms_good_reg > pwr_timeout_ms_reg)
                        begin
                            mode_next = MODE_POWER_LOST;
                        end
                        else if (ms_good_reg > sig_timeout_ms_reg)
                        begin
                            mode_next = MODE_SIGNAL_LOST;
                        end
                    end
                    MODE_POWER_LOST:
                    begin
                        do_restart = (ms_restart_reg > reconnect_interval_ms_reg);
                    end
                    default:
                    begin
                        if (ms_good_reg > pwr_timeout_ms_reg)
                        begin
                            mode_next = MODE_POWER_LOST;
                        end
                    end
                endcase
            end
            ACT_MANUAL_RESET:
            begin
                do_restart = 1'b1;
            end
            default:
            begin
            end
        endcase

        // Receiver restart, manual or automatic.
        if (do_restart)
        begin
            fail_run_next   = 8'd0;
            mode_next       = MODE_RECONNECTING;
            ms_good_next    = 16'd0;
            ms_restart_next = 16'd0;
            restart_next    = 1'b1;
        end

        // Debounced valid flag, from the updated state.
        if (do_update_valid)
        begin
            if (mode_next != MODE_NORMAL || fail_run_next >= crc_fail_limit_reg)
            begin
                valid_flag_next = 1'b0;
            end
            else if (last_good_next)
            begin
                valid_flag_next = 1'b1;
            end
        end
    end

    // State and result valid update when the request leaves the input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_RECONNECTING;
            ms_good_reg    <= 16'd0;
            ms_restart_reg <= 16'd0;
            fail_run_reg   <= 8'd0;
            last_good_reg  <= 1'b0;
            valid_flag_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                mode_reg       <= mode_next;
                ms_good_reg    <= ms_good_next;
                ms_restart_reg <= ms_restart_next;
                fail_run_reg   <= fail_run_next;
                last_good_reg  <= last_good_next;
                valid_flag_reg <= valid_flag_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            link_state_reg <= mode_code(mode_next);
            data_valid_reg <= valid_flag_next;
            power_lost_reg <= (mode_next == MODE_POWER_LOST);
            fail_count_reg <= fail_run_next;
            restart_reg    <= restart_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign link_state      = link_state_reg;
    assign data_valid      = data_valid_reg;
    assign power_lost      = power_lost_reg;
    assign crc_fail_count  = fail_count_reg;
    assign restart_request = restart_reg;

endmodule

// File: hdl/sls_checker.sv
// Port-level checks for the serial link loss supervisor, and their bind.
// Depends on sls_pkg and serial_link_loss_supervisor.
module sls_checker
    import sls_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  link_state,
    input logic        data_valid,
    input logic        power_lost,
    input logic [7:0]  crc_fail_count,
    input logic        restart_request
);

    // The power lost flag matches the reported link state.
    a_power_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (power_lost == (link_state == LINK_POWER_LOST)))
        else $error("power_lost disagrees with link_state");

    // A restart leaves the link reconnecting with an empty failure run.
    a_restart_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && restart_request) |->
            (link_state == LINK_RECONNECTING && crc_fail_count == 8'd0))
        else $error("restart result does not show a fresh reconnect");

    // The input side only stalls behind a full, stalled result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output backpressure");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(link_state) && $stable(data_valid)
             && $stable(crc_fail_count) && $stable(restart_request)))
        else $error("stalled result changed");

endmodule

bind serial_link_loss_supervisor sls_checker u_sls_checker (.*);

// File: tb/tb_serial_link_loss_supervisor.sv
`timescale 1ns / 100ps
// Testbench for the serial link loss supervisor: directed and random requests,
// a scoreboard class that predicts each result and checks it field by field.
// Depends on sls_pkg and serial_link_loss_supervisor.
module tb_serial_link_loss_supervisor;
    import sls_pkg::*;

    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 200;
    localparam int BURST_TICKS = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    // One result as it appears on the output port.
    typedef struct packed {
        logic [1:0] state;
        logic       valid;
        logic       pwr;
        logic [7:0] fails;
        logic       restart;
    } link_report_t;

    // Predicts the link supervisor and checks its results in order.
    class link_scoreboard;
        logic [15:0] sig_timeout_ms;
        logic [15:0] pwr_timeout_ms;
        logic [7:0]  fail_limit;
        logic [15:0] reconnect_ms;
        logic [1:0]  mode;
        logic [15:0] since_good;
        logic [15:0] since_restart;
        logic [7:0]  fail_run;
        logic        last_good;
        logic        valid_flag;
        link_report_t pending_reports[$];
        int errors;

        function new();
            sig_timeout_ms = RST_SIGNAL_LOST_MS;
            pwr_timeout_ms = RST_POWER_LOST_MS;
            fail_limit     = RST_CRC_FAIL_LIMIT;
            reconnect_ms   = RST_RECONNECT_INTERVAL_MS;
            mode           = LINK_RECONNECTING;
            since_good     = '0;
            since_restart  = '0;
            fail_run       = '0;
            last_good      = 1'b0;
            valid_flag     = 1'b0;
            errors         = 0;
        endfunction

        function void write_register(logic [1:0] index, logic [15:0] data);
            case (index)
                CFG_SIGNAL_LOST_MS:        sig_timeout_ms = data;
                CFG_POWER_LOST_MS:         pwr_timeout_ms = data;
                CFG_CRC_FAIL_LIMIT:        fail_limit = data[7:0];
                CFG_RECONNECT_INTERVAL_MS: reconnect_ms = data;
                default: ;
            endcase
        endfunction

        function void restart_receiver();
            fail_run      = '0;
            mode          = LINK_RECONNECTING;
            since_good    = '0;
            since_restart = '0;
        endfunction

        // Valid clears off normal or at limit, else a good last frame sets it.
        function void refresh_valid();
            if (mode != LINK_NORMAL || fail_run >= fail_limit)
                valid_flag = 1'b0;
            else if (last_good)
                valid_flag = 1'b1;
        endfunction

        // Apply one accepted request and queue the result it should produce.
        function void note_request(logic [2:0] act, logic good);
            link_report_t rep;
            logic restarted;
            restarted = 1'b0;
            case (act)
                ACT_TICK:
                begin
                    if (since_good != TIME_MAX)
                        since_good = since_good + 16'd1;
                    if (since_restart != TIME_MAX)
                        since_restart = since_restart + 16'd1;
                end
                ACT_FRAME_CHECK:
                begin
                    last_good = good;
                    if (good)
                    begin
                        fail_run   = '0;
                        since_good = '0;
                        mode       = LINK_NORMAL;
                    end
                    else if (fail_run < fail_limit)
                    begin
                        fail_run = fail_run + 8'd1;
                    end
                    refresh_valid();
                end
                ACT_SUPERVISE:
                begin
                    case (mode)
                        LINK_NORMAL:
                        begin
                            if (since_good > pwr_timeout_ms)
                                mode = LINK_POWER_LOST;
                            else if (since_good > sig_timeout_ms)
                                mode = LINK_SIGNAL_LOST;
                        end
                        LINK_POWER_LOST:
                        begin
                            if (since_restart > reconnect_ms)
                            begin
                                restart_receiver();
                                restarted = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (since_good > pwr_timeout_ms)
                                mode = LINK_POWER_LOST;
                        end
                    endcase
                    refresh_valid();
                end
                ACT_MANUAL_RESET:
                begin
                    restart_receiver();
                    restarted = 1'b1;
                end
                default: ;
            endcase
            rep.state   = mode;
            rep.valid   = valid_flag;
            rep.pwr     = (mode == LINK_POWER_LOST);
            rep.fails   = fail_run;
            rep.restart = restarted;
            pending_reports.push_back(rep);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_result(link_report_t got);
            link_report_t want;
            if (pending_reports.size() == 0)
            begin
                errors++;
                $error("result arrived with no request pending");
                return;
            end
            want = pending_reports.pop_front();
            compare_field("link_state", want.state, got.state);
            compare_field("data_valid", want.valid, got.valid);
            compare_field("power_lost", want.pwr, got.pwr);
            compare_field("crc_fail_count", want.fails, got.fails);
            compare_field("restart_request", want.restart, got.restart);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_SIGNAL_LOST_MS;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  action = ACT_NONE;
    logic        crc_good = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  link_state;
    logic        data_valid;
    logic        power_lost;
    logic [7:0]  crc_fail_count;
    logic        restart_request;

    link_scoreboard sb;
    bit gaps_on = 1'b1;
    bit stall_on = 1'b1;
    int items_sent = 0;
    int idle_cycles = 0;

    serial_link_loss_supervisor dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .crc_good       (crc_good),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .link_state     (link_state),
        .data_valid     (data_valid),
        .power_lost     (power_lost),
        .crc_fail_count (crc_fail_count),
        .restart_request(restart_request)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Watch both handshakes and feed the scoreboard.
    always @(posedge clk)
    begin
        if (in_valid === 1'b1 && in_stall === 1'b0)
            sb.note_request(action, crc_good);
        if (out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_result(link_report_t'{link_state, data_valid, power_lost,
                                           crc_fail_count, restart_request});
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver side: random stretches of stall.
    initial
    begin
        int len;
        forever
        begin
            len = stall_on ? pick_gap() : 0;
            if (len > 0)
            begin
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
                out_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Ends the run when nothing has moved for too long.
    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Send one request, optionally after a gap, and wait until it is taken.
    task automatic issue_request(input logic [2:0] act, input logic good);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        crc_good <= good;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        items_sent++;
    endtask

    // Stop sending until every pending result has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_reports.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic put_register(input logic [1:0] index, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        sb.write_register(index, data);
        @(posedge clk);
    endtask

    task automatic write_config(input logic [15:0] sig, input logic [15:0] pwr,
                                input logic [7:0] lim, input logic [15:0] rec);
        put_register(CFG_SIGNAL_LOST_MS, sig);
        put_register(CFG_POWER_LOST_MS, pwr);
        put_register(CFG_CRC_FAIL_LIMIT, {8'd0, lim});
        put_register(CFG_RECONNECT_INTERVAL_MS, rec);
        cfg_we <= 1'b0;
    endtask

    // One random sequence: an outage, a CRC failure run, a manual reset
    // or a few arbitrary codes.
    task automatic run_sequence();
        int kind;
        int span;
        int count;
        kind = $urandom_range(0, 99);
        if (kind < 40)
        begin
            issue_request(ACT_FRAME_CHECK, 1'b1);
            span = sb.pwr_timeout_ms + sb.reconnect_ms + 8;
            if (span > 200)
                span = 200;
            count = $urandom_range(0, span);
            repeat (count)
            begin
                issue_request(ACT_TICK, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 3) == 0)
                    issue_request(ACT_SUPERVISE, 1'($urandom_range(0, 1)));
            end
            issue_request(ACT_SUPERVISE, 1'($urandom_range(0, 1)));
        end
        else if (kind < 65)
        begin
            count = $urandom_range(1, sb.fail_limit + 2);
            repeat (count)
                issue_request(ACT_FRAME_CHECK, $urandom_range(0, 9) == 0);
            issue_request(ACT_SUPERVISE, 1'($urandom_range(0, 1)));
        end
        else if (kind < 80)
        begin
            issue_request(ACT_MANUAL_RESET, 1'($urandom_range(0, 1)));
            issue_request(ACT_FRAME_CHECK, 1'($urandom_range(0, 1)));
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                issue_request(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        int phase_end;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: unused codes, CRC flags, supervise, manual reset.
        for (int k = 0; k < 4; k++)
            issue_request(ACT_NONE + 3'(k), k[0]);
        issue_request(ACT_FRAME_CHECK, 1'b0);
        issue_request(ACT_FRAME_CHECK, 1'b1);
        issue_request(ACT_SUPERVISE, 1'b0);
        issue_request(ACT_TICK, 1'b1);
        issue_request(ACT_SUPERVISE, 1'b1);
        issue_request(ACT_MANUAL_RESET, 1'b0);
        issue_request(ACT_FRAME_CHECK, 1'b0);
        issue_request(ACT_FRAME_CHECK, 1'b1);
        drain_results();

        // Zero signal and reconnect thresholds, a power threshold of 2 and a zero
        // failure limit: fast walk to power lost and an automatic restart.
        write_config(16'd0, 16'd2, 8'd0, 16'd0);
        issue_request(ACT_FRAME_CHECK, 1'b1);
        issue_request(ACT_TICK, 1'b0);
        issue_request(ACT_SUPERVISE, 1'b0);
        issue_request(ACT_TICK, 1'b0);
        issue_request(ACT_TICK, 1'b1);
        issue_request(ACT_SUPERVISE, 1'b0);
        issue_request(ACT_SUPERVISE, 1'b1);
        issue_request(ACT_FRAME_CHECK, 1'b0);
        drain_results();

        // Thresholds at the maximum: a burst of ticks with no gaps and no
        // stalls leaves the link normal.
        write_config(TIME_MAX, TIME_MAX, 8'd255, TIME_MAX);
        issue_request(ACT_FRAME_CHECK, 1'b1);
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        repeat (BURST_TICKS)
            issue_request(ACT_TICK, 1'($urandom_range(0, 1)));
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        issue_request(ACT_SUPERVISE, 1'b0);
        issue_request(ACT_FRAME_CHECK, 1'b0);
        issue_request(ACT_SUPERVISE, 1'b1);
        drain_results();
        write_config(TIME_MAX, TIME_MAX - 16'd1, 8'd255, TIME_MAX);
        issue_request(ACT_SUPERVISE, 1'b0);
        issue_request(ACT_SUPERVISE, 1'b0);
        drain_results();
        write_config(TIME_MAX, TIME_MAX - 16'd1, 8'd255, TIME_MAX - 16'd1);
        issue_request(ACT_SUPERVISE, 1'b1);
        drain_results();

        // Random phases, each under its own configuration.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase == 0)
                write_config(16'd0, 16'd0, 8'd0, 16'd0);
            else if (phase == 2)
                write_config(TIME_MAX, TIME_MAX, 8'd255, TIME_MAX);
            else
                write_config(16'($urandom_range(0, 40)), 16'($urandom_range(0, 80)),
                             8'($urandom_range(0, 10)), 16'($urandom_range(0, 120)));
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                gaps_on  = ($urandom_range(0, 4) != 0);
                stall_on = ($urandom_range(0, 4) != 0);
                run_sequence();
                if ($urandom_range(0, 49) == 0)
                    drain_results();
            end
            drain_results();
        end

        repeat (2) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
